/* design/midi_note_remapper_core_assert.svh */
// Assertion macros for the note remapper core.
`ifndef MIDI_NOTE_REMAPPER_CORE_ASSERT_SVH
`define MIDI_NOTE_REMAPPER_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define MNR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication checked at every clock edge outside reset.
`define MNR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

/* design/mnr_pkg.sv */
// Package for the note remapper: constants, codes and types.
`default_nettype none
package mnr_pkg;
    localparam int ACTIVE_SLOTS = 16;
    localparam int SLOT_W = $clog2(ACTIVE_SLOTS);
    localparam int CNT_W = $clog2(ACTIVE_SLOTS + 1);
    localparam int NUM_CHANNELS = 16;

    localparam logic [1:0] REQ_MIDI  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_PANIC = 2'd3;

    localparam logic [2:0] KIND_SEND  = 3'd0;
    localparam logic [2:0] KIND_DROP  = 3'd1;
    localparam logic [2:0] KIND_CSTART = 3'd2;
    localparam logic [2:0] KIND_CSTOP = 3'd3;
    localparam logic [2:0] KIND_STOPALL = 3'd4;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CC       = 8'hB0;
    localparam logic [7:0] ST_SYS      = 8'hF0;
    localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;
    localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;

    typedef struct packed {
        logic       mode;
        logic       pad;
        logic [4:0] chan;
        logic [6:0] target;
        logic       muted;
        logic       enabled;
    } map_entry_t;

    typedef struct packed {
        logic [3:0] src_ch;
        logic [6:0] src_note;
        logic [3:0] out_ch;
        logic [6:0] out_note;
    } slot_t;
endpackage
`default_nettype wire

/* design/midi_note_remapper_core.sv */
// Top level of the MIDI note remapper: sequencer, note map, active-note table.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+---------------------
//  request | req_type msg_* map_*                            | start & !busy
//  result  | out_kind out_status out_data1/2 clip_note last  | out_valid, 1 cycle
//  config  | cfg_we cfg_index cfg_wdata                      | cfg_we, no wait
//
// Steps: a message decided at once (ignored, non-note, clip, drop) passes map
// read and decide only. A note message that reaches the table goes on through
// scan, any removal shifts and the final send; a retriggered note-on rescans
// from slot 0 after each removal. Flush and map write send a note-off per slot,
// then a post step; panic then adds the controller messages, two per channel.
// The single slot compare/shift unit and the one-read map memory set the rate.
// Reset clears control, table count, clip flags and the note-map valid bits.
// Results cannot be stalled. For a message or a panic the last result, if any, is
// on the ports in the cycle busy falls; a flush or map write gives its last note-off before that.
`default_nettype none
module midi_note_remapper_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] msg_status,
    input  wire logic [7:0] msg_data1,
    input  wire logic [7:0] msg_data2,
    input  wire logic [6:0] map_index,
    input  wire logic       map_enabled,
    input  wire logic       map_muted,
    input  wire logic [6:0] map_target,
    input  wire logic [4:0] map_channel,
    input  wire logic       map_clip_pad,
    input  wire logic       map_clip_mode,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic       cfg_wdata,
    output logic            out_valid,
    output logic [2:0]      out_kind,
    output logic [7:0]      out_status,
    output logic [7:0]      out_data1,
    output logic [7:0]      out_data2,
    output logic [6:0]      clip_note,
    output logic            last
);
    import mnr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;  // map read issued
    localparam logic [3:0] S_DEC   = 4'd2;  // decide message action
    localparam logic [3:0] S_SCAN  = 4'd3;  // search table for source pair
    localparam logic [3:0] S_SHIFT = 4'd4;  // remove one slot, shifting up
    localparam logic [3:0] S_FIN   = 4'd5;  // final send of note message
    localparam logic [3:0] S_FLUSH = 4'd6;  // note-off per slot
    localparam logic [3:0] S_POST  = 4'd7;  // after flush: write map or panic
    localparam logic [3:0] S_CC    = 4'd8;  // panic controller messages

    logic [3:0] state_reg, state_next;
    logic       pass_reg, open_reg;

    // request latches
    logic [1:0] req_reg;
    logic [7:0] st_reg, d1_reg, d2_reg;
    map_entry_t wentry_reg;
    logic [6:0] widx_reg;

    // note map memory with per-entry valid bits
    map_entry_t map_mem [128];
    logic [127:0] map_vld_reg;
    map_entry_t   map_rd_reg;
    logic         map_rd_vld_reg;
    logic [127:0] clip_reg;

    slot_t      slots_reg [ACTIVE_SLOTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [5:0] cc_reg;

    // outcome of note message
    logic       on_reg;
    logic       known_reg;
    logic [3:0] och_reg;
    logic [6:0] onote_reg;

    // result register
    logic       ov_reg, last_reg;
    logic [2:0] kind_reg;
    logic [7:0] ost_reg, od1_reg, od2_reg;
    logic [6:0] cn_reg;

    map_entry_t ent;
    logic [3:0] in_ch;
    logic [6:0] note;
    slot_t      cur;
    logic       hit;
    logic [SLOT_W-1:0] idx_s;

    assign ent   = map_rd_vld_reg ? map_rd_reg : '0;
    assign in_ch = st_reg[3:0];
    assign note  = d1_reg[6:0];
    assign idx_s = idx_reg[SLOT_W-1:0];
    assign cur   = slots_reg[idx_s];
    assign hit   = (cur.src_ch == in_ch) && (cur.src_note == note);

    function automatic logic [3:0] ovr_ch(map_entry_t e, logic [3:0] c);
        logic [4:0] m;
        begin
            m = e.chan - 5'd1;
            ovr_ch = (e.chan != 5'd0) ? m[3:0] : c;
        end
    endfunction

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= 1'b0;
            open_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0) pass_reg <= cfg_wdata;
            else                   open_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        map_rd_reg <= map_mem[note];
        if (state_reg == S_POST && req_reg == REQ_WRITE)
            map_mem[widx_reg] <= wentry_reg;
    end

    // control plus emit logic in one clocked sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            map_vld_reg    <= '0;
            clip_reg       <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            cc_reg         <= '0;
            ov_reg         <= 1'b0;
            last_reg       <= 1'b0;
            kind_reg       <= KIND_DROP;
            ost_reg        <= '0;
            od1_reg        <= '0;
            od2_reg        <= '0;
            cn_reg         <= '0;
            map_rd_vld_reg <= 1'b0;
        end
        else
        begin
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
            kind_reg <= KIND_DROP;
            ost_reg  <= '0;
            od1_reg  <= '0;
            od2_reg  <= '0;
            cn_reg   <= '0;
            map_rd_vld_reg <= map_vld_reg[note];
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                    begin
                        req_reg    <= req_type;
                        st_reg     <= msg_status;
                        d1_reg     <= msg_data1;
                        d2_reg     <= msg_data2;
                        widx_reg   <= map_index;
                        wentry_reg <= '{mode: map_clip_mode, pad: map_clip_pad,
                                        chan: map_channel, target: map_target,
                                        muted: map_muted, enabled: map_enabled};
                    end
                end
                S_READ: ;
                S_DEC:
                begin
                    on_reg    <= (st_reg[7:4] == ST_NOTE_ON[7:4]) && (d2_reg != 8'd0);
                    known_reg <= 1'b0;
                    och_reg   <= ent.enabled ? ovr_ch(ent, in_ch) : in_ch;
                    onote_reg <= ent.enabled ? ent.target : note;
                    if (st_reg < ST_NOTE_OFF || st_reg >= ST_SYS)
                        ;
                    else if (st_reg[7:4] != ST_NOTE_ON[7:4] &&
                             st_reg[7:4] != ST_NOTE_OFF[7:4])
                    begin
                        ov_reg   <= 1'b1;
                        last_reg <= 1'b1;
                        if (pass_reg && open_reg)
                        begin
                            kind_reg <= KIND_SEND;
                            ost_reg  <= st_reg;
                            od1_reg  <= d1_reg;
                            od2_reg  <= d2_reg;
                        end
                    end
                    else if (d1_reg[7])
                        ;
                    else if (st_reg[7:4] == ST_NOTE_ON[7:4] && d2_reg != 8'd0 && ent.pad)
                    begin
                        clip_reg[note] <= 1'b1;
                        ov_reg   <= 1'b1;
                        last_reg <= 1'b1;
                        kind_reg <= KIND_CSTART;
                        cn_reg   <= note;
                    end
                    else if (!(st_reg[7:4] == ST_NOTE_ON[7:4] && d2_reg != 8'd0) &&
                             clip_reg[note])
                    begin
                        clip_reg[note] <= 1'b0;
                        ov_reg   <= 1'b1;
                        last_reg <= 1'b1;
                        kind_reg <= KIND_CSTOP;
                        cn_reg   <= note;
                    end
                    else if (!(st_reg[7:4] == ST_NOTE_ON[7:4] && d2_reg != 8'd0) && ent.mode)
                        ;
                    else if (st_reg[7:4] == ST_NOTE_ON[7:4] && d2_reg != 8'd0 &&
                             ((ent.enabled && ent.muted) || (!ent.enabled && !pass_reg)))
                    begin
                        ov_reg   <= 1'b1;
                        last_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg < cnt_reg && hit && !on_reg)
                    begin
                        known_reg <= 1'b1;
                        och_reg   <= cur.out_ch;
                        onote_reg <= cur.out_note;
                    end
                    else if (!(idx_reg < cnt_reg && hit))
                        idx_reg <= idx_reg + 1'b1;
                end
                S_SHIFT:
                begin
                    if (idx_reg + 1'b1 < cnt_reg)
                    begin
                        slots_reg[idx_s] <= slots_reg[idx_s + 1'b1];
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        idx_reg <= '0;
                    end
                end
                S_FIN:
                begin
                    ov_reg   <= 1'b1;
                    last_reg <= 1'b1;
                    if (on_reg)
                    begin
                        if (open_reg)
                        begin
                            kind_reg <= KIND_SEND;
                            ost_reg  <= {ST_NOTE_ON[7:4], och_reg};
                            od1_reg  <= {1'b0, onote_reg};
                            od2_reg  <= d2_reg;
                        end
                        if (cnt_reg < CNT_W'(ACTIVE_SLOTS))
                        begin
                            slots_reg[cnt_reg[SLOT_W-1:0]] <= '{src_ch: in_ch,
                                src_note: note, out_ch: och_reg, out_note: onote_reg};
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    else if (!known_reg &&
                             ((ent.enabled && ent.muted) || (!ent.enabled && !pass_reg)))
                        ;
                    else if (open_reg)
                    begin
                        kind_reg <= KIND_SEND;
                        ost_reg  <= {ST_NOTE_OFF[7:4], och_reg};
                        od1_reg  <= {1'b0, onote_reg};
                    end
                end
                S_FLUSH:
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        ov_reg   <= 1'b1;
                        last_reg <= (idx_reg + 1'b1 == cnt_reg) && req_reg != REQ_PANIC;
                        if (open_reg)
                        begin
                            kind_reg <= KIND_SEND;
                            ost_reg  <= {ST_NOTE_OFF[7:4], cur.out_ch};
                            od1_reg  <= {1'b0, cur.out_note};
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_POST:
                begin
                    cnt_reg <= '0;
                    cc_reg  <= '0;
                    if (req_reg == REQ_WRITE)
                        map_vld_reg[widx_reg] <= 1'b1;
                    if (req_reg == REQ_PANIC)
                    begin
                        clip_reg <= '0;
                        ov_reg   <= 1'b1;
                        kind_reg <= KIND_STOPALL;
                    end
                end
                S_CC:
                begin
                    ov_reg   <= 1'b1;
                    last_reg <= (cc_reg == 6'(2 * NUM_CHANNELS - 1));
                    cc_reg   <= cc_reg + 1'b1;
                    if (open_reg)
                    begin
                        kind_reg <= KIND_SEND;
                        ost_reg  <= {ST_CC[7:4], cc_reg[4:1]};
                        od1_reg  <= cc_reg[0] ? CC_ALL_SOUND_OFF : CC_ALL_NOTES_OFF;
                    end
                end
                default: ;
            endcase
        end
    end

    // next-state logic
    logic note_path;
    always_comb
    begin
        note_path  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = (req_type == REQ_MIDI) ? S_READ : S_FLUSH;
            S_READ:  state_next = S_DEC;
            S_DEC:
            begin
                note_path = 1'b1;
                if (st_reg < ST_NOTE_OFF || st_reg >= ST_SYS) note_path = 1'b0;
                else if (st_reg[7:4] != ST_NOTE_ON[7:4] &&
                         st_reg[7:4] != ST_NOTE_OFF[7:4]) note_path = 1'b0;
                else if (d1_reg[7]) note_path = 1'b0;
                else if (st_reg[7:4] == ST_NOTE_ON[7:4] && d2_reg != 8'd0)
                begin
                    if (ent.pad || (ent.enabled && ent.muted) ||
                        (!ent.enabled && !pass_reg)) note_path = 1'b0;
                end
                else if (clip_reg[note] || ent.mode) note_path = 1'b0;
                state_next = note_path ? S_SCAN : S_IDLE;
            end
            S_SCAN:
                if (idx_reg >= cnt_reg) state_next = S_FIN;
                else if (hit)           state_next = S_SHIFT;
            S_SHIFT:
                if (!(idx_reg + 1'b1 < cnt_reg))
                    state_next = (on_reg) ? S_SCAN : S_FIN;
            S_FIN:   state_next = S_IDLE;
            S_FLUSH:
                if (idx_reg >= cnt_reg) state_next = S_POST;
            S_POST:  state_next = (req_reg == REQ_PANIC) ? S_CC : S_IDLE;
            S_CC:
                if (cc_reg == 6'(2 * NUM_CHANNELS - 1)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid  = ov_reg;
    assign out_kind   = kind_reg;
    assign out_status = ost_reg;
    assign out_data1  = od1_reg;
    assign out_data2  = od2_reg;
    assign clip_note  = cn_reg;
    assign last       = last_reg;

`include "midi_note_remapper_core_assert.svh"
    `MNR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(ACTIVE_SLOTS))
    `MNR_ASSERT_IMP(a_last_valid, last_reg, ov_reg)
    `MNR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `MNR_ASSERT_IMP(a_idle_quiet, state_reg == S_IDLE && !$past(busy), !ov_reg)

endmodule
`default_nettype wire
